[rtl/core/pta_pkg.sv]
package pta_pkg;

   localparam int CMD_W        = 3;
   localparam int PAGE_W       = 16;
   localparam int FRAME_PORT_W = 8;
   localparam int AGE_W        = 8;
   localparam int OP_W         = 3;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [CMD_W-1:0] CMD_LOOKUP     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_MAP        = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INVALIDATE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SET_REF    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_AGE        = 3'd4;

   localparam logic [OP_W-1:0] OP_READ   = 3'd0;
   localparam logic [OP_W-1:0] OP_MAP    = 3'd1;
   localparam logic [OP_W-1:0] OP_INVAL  = 3'd2;
   localparam logic [OP_W-1:0] OP_SETREF = 3'd3;
   localparam logic [OP_W-1:0] OP_AGE    = 3'd4;
   localparam logic [OP_W-1:0] OP_NULL   = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]         op;
      logic [PAGE_W-1:0]       page;
      logic [FRAME_PORT_W-1:0] frame;
   } op_type;

   typedef struct packed {
      logic             valid;
      logic             refd;
      logic [AGE_W-1:0] age;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[rtl/core/pta_front.sv]
module pta_front #(
   parameter int PAGE_COUNT = 256
) (
   input  logic                                start,
   input  logic [pta_pkg::CMD_W-1:0]           req_command,
   input  logic [pta_pkg::PAGE_W-1:0]          req_page_number,
   input  logic [pta_pkg::FRAME_PORT_W-1:0]    req_frame_number,
   input  pta_pkg::queue_status_type           q_status,
   input  logic                                clearing,
   output logic                                busy,
   output logic                                push,
   output pta_pkg::op_type                     push_data
);

   localparam int LW = pta_pkg::PAGE_W + 1;
   localparam logic [LW-1:0] PAGE_LIMIT = LW'(PAGE_COUNT);

   logic in_range;

   assign busy     = q_status.full | clearing;
   assign push     = start & ~busy;
   assign in_range = ({1'b0, req_page_number} < PAGE_LIMIT);

   always_comb begin
      push_data.page  = req_page_number;
      push_data.frame = req_frame_number;
      if (req_command == pta_pkg::CMD_AGE) begin
         push_data.op = pta_pkg::OP_AGE;
      end else if (!in_range) begin
         push_data.op = pta_pkg::OP_NULL;
      end else begin
         case (req_command)
            pta_pkg::CMD_MAP: begin
               push_data.op = pta_pkg::OP_MAP;
            end
            pta_pkg::CMD_INVALIDATE: begin
               push_data.op = pta_pkg::OP_INVAL;
            end
            pta_pkg::CMD_SET_REF: begin
               push_data.op = pta_pkg::OP_SETREF;
            end
            default: begin
               push_data.op = pta_pkg::OP_READ;
            end
         endcase
      end
   end

endmodule

[rtl/core/pta_queue.sv]
module pta_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  pta_pkg::op_type            push_data,
   input  logic                       pop,
   output pta_pkg::op_type            pop_data,
   output pta_pkg::queue_status_type  status
);

   localparam int DEPTH = pta_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   pta_pkg::op_type slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign pop_data     = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/pta_back.sv]
module pta_back #(
   parameter int PAGE_COUNT  = 256,
   parameter int FRAME_WIDTH = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pta_pkg::queue_status_type         q_status,
   input  pta_pkg::op_type                   q_data,
   output logic                              q_pop,
   output logic                              clearing,
   output logic                              rsp_valid,
   output logic                              rsp_in_range,
   output logic                              rsp_hit,
   output logic [pta_pkg::FRAME_PORT_W-1:0]  rsp_frame_out,
   output logic [pta_pkg::AGE_W-1:0]         rsp_age_value
);

   localparam int IW  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int FPW = pta_pkg::FRAME_PORT_W;
   localparam int SW  = (FRAME_WIDTH < FPW) ? FRAME_WIDTH : FPW;
   localparam int AW  = pta_pkg::AGE_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(PAGE_COUNT - 1);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_RMW   = 2'd2;
   localparam logic [1:0] ST_AGE   = 2'd3;

   pta_pkg::entry_type entry_mem_ff [PAGE_COUNT];
   logic [SW-1:0]      frame_mem_ff [PAGE_COUNT];

   logic [1:0]         state_ff, state_in;
   logic [IW-1:0]      idx_ff, idx_in;
   pta_pkg::op_type    op_ff, op_in;
   pta_pkg::entry_type rd_entry_ff;
   logic [SW-1:0]      rd_frame_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_in_range_ff, rsp_in_range_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [FPW-1:0]     rsp_frame_ff, rsp_frame_in;
   logic [AW-1:0]      rsp_age_ff, rsp_age_in;

   logic [IW-1:0]      rd_addr;
   logic [IW-1:0]      wr_addr;
   logic               wr_en;
   pta_pkg::entry_type wr_entry;
   logic               frame_wr_en;

   assign clearing      = (state_ff == ST_CLEAR);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_in_range  = rsp_in_range_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_frame_out = rsp_frame_ff;
   assign rsp_age_value = rsp_age_ff;

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      op_in           = op_ff;
      rd_addr         = idx_ff;
      wr_addr         = idx_ff;
      wr_en           = 1'b0;
      wr_entry        = '0;
      frame_wr_en     = 1'b0;
      q_pop           = 1'b0;
      rsp_valid_in    = 1'b0;
      rsp_in_range_in = 1'b0;
      rsp_hit_in      = 1'b0;
      rsp_frame_in    = '0;
      rsp_age_in      = '0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop = 1'b1;
               op_in = q_data;
               case (q_data.op)
                  pta_pkg::OP_NULL: begin
                     rsp_valid_in = 1'b1;
                  end
                  pta_pkg::OP_AGE: begin
                     rd_addr  = '0;
                     idx_in   = '0;
                     state_in = ST_AGE;
                  end
                  default: begin
                     rd_addr  = q_data.page[IW-1:0];
                     state_in = ST_RMW;
                  end
               endcase
            end
         end
         ST_RMW: begin
            wr_addr         = op_ff.page[IW-1:0];
            rsp_valid_in    = 1'b1;
            rsp_in_range_in = 1'b1;
            rsp_hit_in      = rd_entry_ff.valid;
            rsp_frame_in    = rd_entry_ff.valid ? FPW'(rd_frame_ff) : '0;
            rsp_age_in      = rd_entry_ff.age;
            state_in        = ST_IDLE;
            case (op_ff.op)
               pta_pkg::OP_MAP: begin
                  wr_en          = 1'b1;
                  wr_entry.valid = 1'b1;
                  wr_entry.refd  = 1'b1;
                  frame_wr_en    = 1'b1;
                  rsp_hit_in     = 1'b1;
                  rsp_frame_in   = FPW'(op_ff.frame[SW-1:0]);
                  rsp_age_in     = '0;
               end
               pta_pkg::OP_INVAL: begin
                  wr_en        = 1'b1;
                  rsp_hit_in   = 1'b0;
                  rsp_frame_in = '0;
                  rsp_age_in   = '0;
               end
               pta_pkg::OP_SETREF: begin
                  wr_en         = 1'b1;
                  wr_entry      = rd_entry_ff;
                  wr_entry.refd = 1'b1;
               end
               default: begin
               end
            endcase
         end
         ST_AGE: begin
            wr_en          = rd_entry_ff.valid;
            wr_entry.valid = 1'b1;
            wr_entry.refd  = 1'b0;
            wr_entry.age   = {rd_entry_ff.refd, rd_entry_ff.age[AW-1:1]};
            rd_addr        = idx_ff + 1'b1;
            idx_in         = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      rsp_in_range_ff <= rsp_in_range_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_frame_ff    <= rsp_frame_in;
      rsp_age_ff      <= rsp_age_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= entry_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (frame_wr_en) begin
         frame_mem_ff[wr_addr] <= op_ff.frame[SW-1:0];
      end
      rd_frame_ff <= frame_mem_ff[rd_addr];
   end

endmodule

[rtl/core/page_table_aging_engine.sv]
// Page table with aging LRU counters. After reset the block clears every entry of
// its entry memory and holds busy high meanwhile. Commands are taken when start
// is high and busy is low, land in a two-entry queue, and are carried out in order:
// lookup, map, invalidate and set-reference take a registered read of the entry
// memory, then the write back for map, invalidate and set-reference; a page out of
// range is answered from the idle state without a memory access; and an aging tick
// walks the entry memory one entry per cycle. Each command yields one result, shown
// on the rsp_ ports for exactly one cycle with rsp_valid high; results are never held
// back, so the receiver must take every result in the cycle it appears. Busy rises
// only while the queue is full or the clearing pass runs.
module page_table_aging_engine #(
   parameter int PAGE_COUNT  = 256,
   parameter int FRAME_WIDTH = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [pta_pkg::CMD_W-1:0]         req_command,
   input  logic [pta_pkg::PAGE_W-1:0]        req_page_number,
   input  logic [pta_pkg::FRAME_PORT_W-1:0]  req_frame_number,
   output logic                              rsp_valid,
   output logic                              rsp_in_range,
   output logic                              rsp_hit,
   output logic [pta_pkg::FRAME_PORT_W-1:0]  rsp_frame_out,
   output logic [pta_pkg::AGE_W-1:0]         rsp_age_value
);

   pta_pkg::queue_status_type q_status;
   pta_pkg::op_type           push_data;
   pta_pkg::op_type           pop_data;
   logic                      push;
   logic                      pop;
   logic                      clearing;

   pta_front #(
      .PAGE_COUNT (PAGE_COUNT)
   ) u_front (
      .start            (start),
      .req_command      (req_command),
      .req_page_number  (req_page_number),
      .req_frame_number (req_frame_number),
      .q_status         (q_status),
      .clearing         (clearing),
      .busy             (busy),
      .push             (push),
      .push_data        (push_data)
   );

   pta_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   pta_back #(
      .PAGE_COUNT  (PAGE_COUNT),
      .FRAME_WIDTH (FRAME_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_data        (pop_data),
      .q_pop         (pop),
      .clearing      (clearing),
      .rsp_valid     (rsp_valid),
      .rsp_in_range  (rsp_in_range),
      .rsp_hit       (rsp_hit),
      .rsp_frame_out (rsp_frame_out),
      .rsp_age_value (rsp_age_value)
   );

endmodule

[rtl/core/pta_checker.sv]
module pta_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              busy,
   input  logic                              rsp_valid,
   input  logic                              rsp_in_range,
   input  logic                              rsp_hit,
   input  logic [pta_pkg::FRAME_PORT_W-1:0]  rsp_frame_out,
   input  logic [pta_pkg::AGE_W-1:0]         rsp_age_value
);

   // The clearing pass must hold off commands right after reset.
   assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_in_range) |->
         (!rsp_hit && rsp_frame_out == '0 && rsp_age_value == '0))
      else $error("out-of-range result carries data");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_frame_out == '0))
      else $error("frame shown on a miss");

endmodule

bind page_table_aging_engine pta_checker u_checker (.*);
